// ===== src/sync_header_frame_deframer_core_assert.svh =====
// assertion macros for the sync header frame deframer
// expects clk and rst_n in the scope of use
`ifndef SYNC_HEADER_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define SYNC_HEADER_FRAME_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SHFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SHFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/shfd_pkg.sv =====
// shared types and constants for the sync header frame deframer
// no dependencies
`default_nettype none

package shfd_pkg;

  localparam logic [7:0] SYNC0 = 8'hCD;
  localparam logic [7:0] SYNC1 = 8'hEB;
  localparam logic [7:0] SYNC2 = 8'hD7;

  // fields per frame, 1 to 32
  localparam int ITEMS = 23;
  localparam logic [5:0] ITEMS_W = 6'(ITEMS);
  localparam logic [4:0] LAST_INDEX = 5'(ITEMS - 1);

  typedef struct packed {
    logic [31:0] word;
    logic [4:0]  index;
    logic        last;
  } shfd_res_t;

endpackage

`default_nettype wire

// ===== src/sync_header_frame_deframer_core.sv =====
// top level of the sync header frame deframer
// depends on shfd_pkg, shfd_in_stage, shfd_parse, shfd_out_stage and the assert header
//
//  port group | direction | contents
//  in_        | receive   | rx_byte, one serial byte per item
//  out_       | send      | field_word, field_index, frame_last
//
// one byte is taken per clock unless in_stall holds it off; an item passes an
// input register and the parser, and a field item is loaded into the result
// register when its fourth byte leaves the input register as the parser steps
// reset returns the parser to hunting for the first sync byte
// in_stall rises only while the input register is full and the result
// register holds an item that is stalled
`default_nettype none

`include "sync_header_frame_deframer_core_assert.svh"

module sync_header_frame_deframer_core
  import shfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [31:0]     out_field_word,
  output logic [4:0]      out_field_index,
  output logic            out_frame_last
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       out_free;
  logic       step;
  logic       res_valid;
  shfd_res_t  res;

  assign step = s1_valid && out_free;

  shfd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .consume    (out_free),
    .s1_valid   (s1_valid),
    .s1_byte    (s1_byte)
  );

  shfd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (s1_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  shfd_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (res_valid),
    .res             (res),
    .free            (out_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_field_word  (out_field_word),
    .out_field_index (out_field_index),
    .out_frame_last  (out_frame_last)
  );

  `SHFD_ASSERT_NOW(a_stall_needs_full_out, in_stall, out_valid && out_stall, "input stalled without a blocked item")
  `SHFD_ASSERT_NOW(a_last_index, out_valid && out_frame_last, out_field_index == LAST_INDEX, "last flag on wrong field")
  `SHFD_ASSERT_NOW(a_index_range, out_valid, {1'b0, out_field_index} < ITEMS_W, "field index out of frame")
  `SHFD_ASSERT_NEXT(a_result_loaded, res_valid, out_valid, "field item lost at result register")

endmodule

`default_nettype wire

// ===== src/shfd_in_stage.sv =====
// input register for received bytes
// depends on nothing but the consume handshake from the result register side
`default_nettype none

module shfd_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       consume,
  output logic            s1_valid,
  output logic [7:0]      s1_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       load;

  assign in_stall = valid_r && !consume;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule

`default_nettype wire

// ===== src/shfd_parse.sv =====
// sync hunt, header drop and field assembly state machine
// depends on shfd_pkg
`default_nettype none

module shfd_parse
  import shfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output logic            res_valid,
  output shfd_res_t       res
);

  typedef enum logic [2:0] {
    PH_HUNT0 = 3'd0,
    PH_HUNT1 = 3'd1,
    PH_HUNT2 = 3'd2,
    PH_HEAD  = 3'd3,
    PH_DATA  = 3'd4
  } phase_t;

  phase_t      phase_r, phase_nxt, restart;
  logic [2:0]  bif_r, bif_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic        last;

  assign restart = (rx_byte == SYNC0) ? PH_HUNT1 : PH_HUNT0;
  assign last    = ({1'b0, cnt_r} + 6'd1) >= ITEMS_W;

  always_comb begin
    phase_nxt = phase_r;
    bif_nxt   = bif_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    res_valid = 1'b0;
    res.word  = {rx_byte, acc_r};
    res.index = cnt_r;
    res.last  = last;
    case (phase_r)
      PH_HUNT1: begin
        phase_nxt = (rx_byte == SYNC1) ? PH_HUNT2 : restart;
      end
      PH_HUNT2: begin
        phase_nxt = (rx_byte == SYNC2) ? PH_HEAD : restart;
      end
      PH_HEAD: begin
        phase_nxt = PH_DATA;
        bif_nxt   = 3'd0;
        cnt_nxt   = 5'd0;
      end
      PH_DATA: begin
        if (bif_r < 3'd3) begin
          case (bif_r[1:0])
            2'd0:    acc_nxt[7:0]   = rx_byte;
            2'd1:    acc_nxt[15:8]  = rx_byte;
            default: acc_nxt[23:16] = rx_byte;
          endcase
          bif_nxt = bif_r + 3'd1;
        end else if (bif_r == 3'd3) begin
          res_valid = 1'b1;
          bif_nxt   = 3'd4;
        end else begin
          bif_nxt = 3'd0;
          if (last) begin
            cnt_nxt   = 5'd0;
            phase_nxt = PH_HUNT0;
          end else begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
      end
      default: begin
        phase_nxt = restart;
      end
    endcase
    res_valid = res_valid && step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT0;
      bif_r   <= 3'd0;
      cnt_r   <= 5'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      bif_r   <= bif_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/shfd_out_stage.sv =====
// result register holding one finished field item
// depends on shfd_pkg
`default_nettype none

module shfd_out_stage
  import shfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  shfd_res_t       res,
  output logic            free,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [31:0]     out_field_word,
  output logic [4:0]      out_field_index,
  output logic            out_frame_last
);

  logic      valid_r, valid_nxt;
  shfd_res_t data_r;

  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid       = valid_r;
  assign out_field_word  = data_r.word;
  assign out_field_index = data_r.index;
  assign out_frame_last  = data_r.last;

endmodule

`default_nettype wire
